// File: design/page_framebuffer_glyph_renderer_assert.svh
// Assertion macros for the glyph renderer checker
`ifndef PAGE_FRAMEBUFFER_GLYPH_RENDERER_ASSERT_SVH
`define PAGE_FRAMEBUFFER_GLYPH_RENDERER_ASSERT_SVH
// implication under synchronous reset
`define PFG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication under synchronous reset
`define PFG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: design/pfg_pkg.sv
package pfg_pkg;
    localparam int DisplayWidth = 128;
    localparam int PageCount    = 8;
    localparam int ColW  = $clog2(DisplayWidth);
    localparam int PageW = (PageCount > 1) ? $clog2(PageCount) : 1;
    localparam int StoreDepth = PageCount * DisplayWidth;
    localparam int AddrW = $clog2(StoreDepth);
    localparam int ScreenRows = PageCount * 8;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_GLYPH = 3'd1;
    localparam logic [2:0] OP_PIXEL = 3'd2;
    localparam logic [2:0] OP_HLINE = 3'd3;
    localparam logic [2:0] OP_BATT  = 3'd4;
    localparam logic [2:0] OP_SAT   = 3'd5;
    localparam logic [2:0] OP_READ  = 3'd6;

    function automatic logic [34:0] glyph_bits(input logic [7:0] code);
        logic [6:0] idx;
        logic [34:0] g;
        idx = (code < 8'h20 || code > 8'h7E) ? 7'd31 : 7'(code - 8'h20);
        unique case (idx)
            7'd0: g = {7'h00,7'h00,7'h00,7'h00,7'h00};
            7'd1: g = {7'h00,7'h00,7'h5F,7'h00,7'h00};
            7'd2: g = {7'h00,7'h07,7'h00,7'h07,7'h00};
            7'd3: g = {7'h14,7'h7F,7'h14,7'h7F,7'h14};
            7'd4: g = {7'h12,7'h2A,7'h7F,7'h2A,7'h24};
            7'd5: g = {7'h62,7'h64,7'h08,7'h13,7'h23};
            7'd6: g = {7'h50,7'h22,7'h55,7'h49,7'h36};
            7'd7: g = {7'h00,7'h00,7'h03,7'h05,7'h00};
            7'd8: g = {7'h00,7'h41,7'h22,7'h1C,7'h00};
            7'd9: g = {7'h00,7'h1C,7'h22,7'h41,7'h00};
            7'd10: g = {7'h14,7'h08,7'h3E,7'h08,7'h14};
            7'd11: g = {7'h08,7'h08,7'h3E,7'h08,7'h08};
            7'd12: g = {7'h00,7'h00,7'h30,7'h50,7'h00};
            7'd13: g = {7'h08,7'h08,7'h08,7'h08,7'h08};
            7'd14: g = {7'h00,7'h00,7'h60,7'h60,7'h00};
            7'd15: g = {7'h02,7'h04,7'h08,7'h10,7'h20};
            7'd16: g = {7'h3E,7'h45,7'h49,7'h51,7'h3E};
            7'd17: g = {7'h00,7'h40,7'h7F,7'h42,7'h00};
            7'd18: g = {7'h46,7'h49,7'h51,7'h61,7'h42};
            7'd19: g = {7'h31,7'h4B,7'h45,7'h41,7'h21};
            7'd20: g = {7'h10,7'h7F,7'h12,7'h14,7'h18};
            7'd21: g = {7'h39,7'h45,7'h45,7'h45,7'h27};
            7'd22: g = {7'h30,7'h49,7'h49,7'h4A,7'h3C};
            7'd23: g = {7'h03,7'h05,7'h09,7'h71,7'h01};
            7'd24: g = {7'h36,7'h49,7'h49,7'h49,7'h36};
            7'd25: g = {7'h1E,7'h29,7'h49,7'h49,7'h06};
            7'd26: g = {7'h00,7'h00,7'h36,7'h36,7'h00};
            7'd27: g = {7'h00,7'h00,7'h36,7'h56,7'h00};
            7'd28: g = {7'h00,7'h41,7'h22,7'h14,7'h08};
            7'd29: g = {7'h14,7'h14,7'h14,7'h14,7'h14};
            7'd30: g = {7'h08,7'h14,7'h22,7'h41,7'h00};
            7'd31: g = {7'h06,7'h09,7'h51,7'h01,7'h02};
            7'd32: g = {7'h3E,7'h41,7'h79,7'h49,7'h32};
            7'd33: g = {7'h7E,7'h11,7'h11,7'h11,7'h7E};
            7'd34: g = {7'h36,7'h49,7'h49,7'h49,7'h7F};
            7'd35: g = {7'h22,7'h41,7'h41,7'h41,7'h3E};
            7'd36: g = {7'h1C,7'h22,7'h41,7'h41,7'h7F};
            7'd37: g = {7'h41,7'h49,7'h49,7'h49,7'h7F};
            7'd38: g = {7'h01,7'h09,7'h09,7'h09,7'h7F};
            7'd39: g = {7'h7A,7'h49,7'h49,7'h41,7'h3E};
            7'd40: g = {7'h7F,7'h08,7'h08,7'h08,7'h7F};
            7'd41: g = {7'h00,7'h41,7'h7F,7'h41,7'h00};
            7'd42: g = {7'h01,7'h3F,7'h41,7'h40,7'h20};
            7'd43: g = {7'h41,7'h22,7'h14,7'h08,7'h7F};
            7'd44: g = {7'h40,7'h40,7'h40,7'h40,7'h7F};
            7'd45: g = {7'h7F,7'h02,7'h0C,7'h02,7'h7F};
            7'd46: g = {7'h7F,7'h10,7'h08,7'h04,7'h7F};
            7'd47: g = {7'h3E,7'h41,7'h41,7'h41,7'h3E};
            7'd48: g = {7'h06,7'h09,7'h09,7'h09,7'h7F};
            7'd49: g = {7'h5E,7'h21,7'h51,7'h41,7'h3E};
            7'd50: g = {7'h46,7'h29,7'h19,7'h09,7'h7F};
            7'd51: g = {7'h31,7'h49,7'h49,7'h49,7'h46};
            7'd52: g = {7'h01,7'h01,7'h7F,7'h01,7'h01};
            7'd53: g = {7'h3F,7'h40,7'h40,7'h40,7'h3F};
            7'd54: g = {7'h1F,7'h20,7'h40,7'h20,7'h1F};
            7'd55: g = {7'h3F,7'h40,7'h38,7'h40,7'h3F};
            7'd56: g = {7'h63,7'h14,7'h08,7'h14,7'h63};
            7'd57: g = {7'h07,7'h08,7'h70,7'h08,7'h07};
            7'd58: g = {7'h43,7'h45,7'h49,7'h51,7'h61};
            7'd59: g = {7'h00,7'h41,7'h41,7'h7F,7'h00};
            7'd60: g = {7'h20,7'h10,7'h08,7'h04,7'h02};
            7'd61: g = {7'h00,7'h7F,7'h41,7'h41,7'h00};
            7'd62: g = {7'h04,7'h02,7'h01,7'h02,7'h04};
            7'd63: g = {7'h40,7'h40,7'h40,7'h40,7'h40};
            7'd64: g = {7'h00,7'h04,7'h02,7'h01,7'h00};
            7'd65: g = {7'h78,7'h54,7'h54,7'h54,7'h20};
            7'd66: g = {7'h38,7'h44,7'h44,7'h48,7'h7F};
            7'd67: g = {7'h20,7'h44,7'h44,7'h44,7'h38};
            7'd68: g = {7'h7F,7'h48,7'h44,7'h44,7'h38};
            7'd69: g = {7'h18,7'h54,7'h54,7'h54,7'h38};
            7'd70: g = {7'h02,7'h01,7'h09,7'h7E,7'h08};
            7'd71: g = {7'h3E,7'h52,7'h52,7'h52,7'h0C};
            7'd72: g = {7'h78,7'h04,7'h04,7'h08,7'h7F};
            7'd73: g = {7'h00,7'h40,7'h7D,7'h44,7'h00};
            7'd74: g = {7'h00,7'h3D,7'h44,7'h40,7'h20};
            7'd75: g = {7'h00,7'h44,7'h28,7'h10,7'h7F};
            7'd76: g = {7'h00,7'h40,7'h7F,7'h41,7'h00};
            7'd77: g = {7'h78,7'h04,7'h18,7'h04,7'h7C};
            7'd78: g = {7'h78,7'h04,7'h04,7'h08,7'h7C};
            7'd79: g = {7'h38,7'h44,7'h44,7'h44,7'h38};
            7'd80: g = {7'h08,7'h14,7'h14,7'h14,7'h7C};
            7'd81: g = {7'h7C,7'h18,7'h14,7'h14,7'h08};
            7'd82: g = {7'h08,7'h04,7'h04,7'h08,7'h7C};
            7'd83: g = {7'h20,7'h54,7'h54,7'h54,7'h48};
            7'd84: g = {7'h20,7'h40,7'h44,7'h3F,7'h04};
            7'd85: g = {7'h7C,7'h20,7'h40,7'h40,7'h3C};
            7'd86: g = {7'h1C,7'h20,7'h40,7'h20,7'h1C};
            7'd87: g = {7'h3C,7'h40,7'h30,7'h40,7'h3C};
            7'd88: g = {7'h44,7'h28,7'h10,7'h28,7'h44};
            7'd89: g = {7'h3C,7'h50,7'h50,7'h50,7'h0C};
            7'd90: g = {7'h44,7'h4C,7'h54,7'h64,7'h44};
            7'd91: g = {7'h00,7'h41,7'h36,7'h08,7'h00};
            7'd92: g = {7'h00,7'h00,7'h7F,7'h00,7'h00};
            7'd93: g = {7'h00,7'h08,7'h36,7'h41,7'h00};
            7'd94: g = {7'h08,7'h10,7'h08,7'h08,7'h10};
            default: g = '0;
        endcase
        return g;
    endfunction
endpackage

// File: design/pfg_ram.sv
module pfg_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/page_framebuffer_glyph_renderer.sv
// A read passes through S_RDWT and S_RDOUT and raises o_read_strobe for one cycle,
// with o_read_byte registered alongside. Glyph, pixel and icon draws visit both
// pages of each column, reading each page byte and writing back the touched ones;
// hline reads and writes each column, clear writes every byte. One command runs
// at a time, with busy high. Reset (i_rst_n low, synchronous) sweeps all StoreDepth
// bytes clear with busy high; results are never stalled by the receiver.
module page_framebuffer_glyph_renderer
    import pfg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_op,
    input  logic signed [8:0] i_pos_x,
    input  logic signed [8:0] i_pos_y,
    input  logic [7:0]        i_char_code,
    input  logic [7:0]        i_percent,
    input  logic              i_fix_flag,
    input  logic [2:0]        i_page_index,
    input  logic [6:0]        i_column_index,
    output logic              o_read_strobe,
    output logic [7:0]        o_read_byte
);
    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_COLRD = 3'd2;  // issue read of current column/page
    localparam logic [2:0] S_COLWR = 3'd3;  // data back: OR and write
    localparam logic [2:0] S_LINE  = 3'd4;  // hline: read issue
    localparam logic [2:0] S_LINEW = 3'd5;
    localparam logic [2:0] S_RDWT  = 3'd6;
    localparam logic [2:0] S_RDOUT = 3'd7;

    logic [2:0]  r_state, n_state;
    logic [AddrW:0] r_cnt, n_cnt;       // sweep counter / column index
    logic        r_half, n_half;        // second page of a column
    logic [2:0]  r_op;
    logic signed [9:0] r_x, r_y;
    logic [34:0] r_glyph;
    logic [3:0]  r_fill;
    logic        r_fix;
    logic        r_rd_ok;
    logic [AddrW-1:0] r_addr, n_addr;
    logic [7:0]  r_mask, n_mask;

    logic              we;
    logic [AddrW-1:0]  waddr, raddr;
    logic [7:0]        wdata, rdata;

    pfg_ram #(.Width(8), .Depth(StoreDepth)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // number of columns for each shape
    logic [3:0] ncols;
    always_comb begin
        unique case (r_op)
            OP_GLYPH: ncols = 4'd5;
            OP_BATT:  ncols = 4'd12;
            OP_SAT:   ncols = 4'd9;
            default:  ncols = 4'd1;
        endcase
    end

    // 7-bit column pattern of current column
    logic [3:0] ci;
    logic [6:0] colbits;
    always_comb begin
        ci = r_cnt[3:0];
        colbits = 7'h00;
        unique case (r_op)
            OP_GLYPH: colbits = r_glyph[7*ci +: 7];
            OP_PIXEL: colbits = 7'h01;
            OP_BATT: begin
                if (ci == 4'd0 || ci == 4'd9) colbits = 7'h3F;
                else if (ci >= 4'd10) colbits = 7'h1E;
                else colbits = ((ci - 4'd1) < r_fill) ? 7'h3F : 7'h21;
            end
            OP_SAT: begin
                unique case (ci)
                    4'd0, 4'd8: colbits = r_fix ? 7'h0E : 7'h00;
                    4'd1, 4'd7: colbits = 7'h0E;
                    4'd2, 4'd6: colbits = r_fix ? 7'h04 : 7'h00;
                    4'd3, 4'd5: colbits = 7'h1E;
                    4'd4:       colbits = 7'h3F;
                    default:    colbits = 7'h00;
                endcase
            end
            default: colbits = 7'h00;
        endcase
    end

    // column pixel placement: rows y..y+6 shifted into two pages
    logic signed [10:0] cx;
    logic signed [10:0] pg;
    logic [2:0]  yoff;
    logic [15:0] sh;
    logic        col_ok, pg_ok;
    logic [7:0]  half_mask;
    always_comb begin
        cx = 11'(r_x) + 11'(ci);
        yoff = r_y[2:0];
        pg = 11'(r_y >>> 3) + 11'(r_half);
        sh = 16'(colbits) << yoff;
        half_mask = r_half ? sh[15:8] : sh[7:0];
        col_ok = (cx >= 0) && (cx < DisplayWidth);
        pg_ok  = (pg >= 0) && (pg < PageCount);
    end

    // battery fill: ceil(8*pct/100) capped; pct from 100 to 254 gives 8, pct 255 gives 0
    function automatic logic [3:0] batt_fill(input logic [7:0] p);
        logic [3:0] f;
        if (p == 8'd255) f = 4'd0;
        else if (p == 8'd0) f = 4'd0;
        else if (p <= 8'd12) f = 4'd1;
        else if (p <= 8'd25) f = 4'd2;
        else if (p <= 8'd37) f = 4'd3;
        else if (p <= 8'd50) f = 4'd4;
        else if (p <= 8'd62) f = 4'd5;
        else if (p <= 8'd75) f = 4'd6;
        else if (p <= 8'd87) f = 4'd7;
        else f = 4'd8;
        return f;
    endfunction

    logic signed [9:0] hy;
    assign hy = r_y;

    logic accept;
    assign accept = start && !busy;
    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_half = r_half;
        n_addr = r_addr;
        n_mask = r_mask;
        we = 1'b0;
        waddr = r_addr;
        wdata = 8'h00;
        raddr = r_addr;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                n_half = 1'b0;
                if (accept) begin
                    // read address is latched here, used by the read in S_RDWT
                    n_addr = AddrW'(i_page_index) * AddrW'(DisplayWidth)
                             + AddrW'(i_column_index);
                    unique case (i_op)
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_GLYPH, OP_PIXEL, OP_BATT, OP_SAT: n_state = S_COLRD;
                        OP_HLINE: n_state = (i_pos_y >= 0 && i_pos_y < ScreenRows)
                                            ? S_LINE : S_IDLE;
                        OP_READ: n_state = S_RDWT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                we = 1'b1;
                waddr = r_cnt[AddrW-1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (AddrW+1)'(StoreDepth - 1)) n_state = S_IDLE;
            end
            S_COLRD: begin
                n_addr = AddrW'(pg[PageW-1:0]) * AddrW'(DisplayWidth) + AddrW'(cx[ColW-1:0]);
                n_mask = (col_ok && pg_ok) ? half_mask : 8'h00;
                raddr = n_addr;
                if (col_ok && pg_ok && half_mask != 8'h00) begin
                    n_state = S_COLWR;
                end else begin
                    n_half = ~r_half;
                    if (r_half) begin
                        n_cnt = r_cnt + 1'b1;
                        if (r_cnt[3:0] == ncols - 4'd1) n_state = S_IDLE;
                    end
                end
            end
            S_COLWR: begin
                we = 1'b1;
                wdata = rdata | r_mask;
                n_half = ~r_half;
                n_state = S_COLRD;
                if (r_half) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt[3:0] == ncols - 4'd1) n_state = S_IDLE;
                end
            end
            S_LINE: begin
                n_addr = AddrW'(hy[9:3]) * AddrW'(DisplayWidth) + AddrW'(r_cnt[ColW-1:0]);
                raddr = n_addr;
                n_mask = 8'd1 << hy[2:0];
                n_state = S_LINEW;
            end
            S_LINEW: begin
                we = 1'b1;
                wdata = rdata | r_mask;
                n_cnt = r_cnt + 1'b1;
                n_state = (r_cnt == (AddrW+1)'(DisplayWidth - 1)) ? S_IDLE : S_LINE;
            end
            S_RDWT:  n_state = S_RDOUT;
            S_RDOUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt <= '0;
            r_half <= 1'b0;
            o_read_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_half <= n_half;
            o_read_strobe <= (r_state == S_RDOUT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_mask <= n_mask;
        if (accept) begin
            r_op <= i_op;
            r_x <= 10'(i_pos_x);
            r_y <= 10'(i_pos_y);
            r_glyph <= glyph_bits(i_char_code);
            r_fill <= batt_fill(i_percent);
            r_fix <= i_fix_flag;
            r_rd_ok <= (32'(i_page_index) < PageCount) && (32'(i_column_index) < DisplayWidth);
        end
        if (r_state == S_RDOUT) begin
            o_read_byte <= r_rd_ok ? rdata : 8'h00;
        end
    end
endmodule

// File: design/pfg_checker.sv
`include "page_framebuffer_glyph_renderer_assert.svh"
module pfg_assert_checker
    import pfg_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [2:0] i_op,
    input logic       o_read_strobe
);
    `PFG_ASSERT_NXT(a_read_busy, i_clk, i_rst_n, start && !busy && i_op == OP_READ, busy)
    `PFG_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_read_strobe, !o_read_strobe)
    `PFG_ASSERT_NXT(a_draw_no_strobe, i_clk, i_rst_n, start && !busy && i_op != OP_READ, !o_read_strobe)
endmodule

bind page_framebuffer_glyph_renderer pfg_assert_checker u_pfg_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_op(i_op), .o_read_strobe(o_read_strobe)
);
